### hdl/vn_pkg.sv
// Package: widths, payload structs and pipeline stage types for the vector normaliser.
package vn_pkg;

    localparam int COMP_WIDTH     = 16;
    localparam int UNIT_FRAC_BITS = 14;
    localparam int LEN_FRAC_BITS  = 8;
    localparam int UNIT_OUT_WIDTH = 16;
    localparam int LEN_OUT_WIDTH  = 24;

    localparam int MAG_W       = COMP_WIDTH;
    localparam int SQ_W        = 2 * COMP_WIDTH;
    localparam int SUM_W       = 2 * COMP_WIDTH;
    localparam int LEN_W       = COMP_WIDTH + LEN_FRAC_BITS;
    localparam int ROOT_STAGES = LEN_W;
    localparam int REM_W       = LEN_W + 2;
    localparam int QUO_W       = UNIT_FRAC_BITS + 1;
    localparam int DIV_STAGES  = QUO_W;
    localparam int DREM_W      = LEN_W + 1;
    localparam int NUM_LANES   = 3;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] comp_x;
        logic signed [COMP_WIDTH-1:0] comp_y;
        logic signed [COMP_WIDTH-1:0] comp_z;
    } t_vec_in;

    typedef struct packed {
        logic signed [UNIT_OUT_WIDTH-1:0] unit_x;
        logic signed [UNIT_OUT_WIDTH-1:0] unit_y;
        logic signed [UNIT_OUT_WIDTH-1:0] unit_z;
        logic [LEN_OUT_WIDTH-1:0]         length_q8;
        logic                             zero_vector;
    } t_vec_out;

    typedef struct packed {
        logic [SUM_W-1:0] s;
        logic [REM_W-1:0] rem;
        logic [LEN_W-1:0] root;
    } t_root_st;

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
    } t_div_st;

endpackage

### hdl/vector3_normalize.sv
// Top level: pipelined 3D vector normaliser with magnitude and three divider lanes.
// Takes one vector per cycle and returns its Q16.8 magnitude and Q2.14 unit vector. The
// stages in order are the sign split, the squares, the sum, the digit-by-digit root (one
// root bit per stage), the three parallel divider lanes (one quotient bit per stage) and
// one output register that applies the clamp, the signs and the zero-vector case. The
// whole pipeline advances whenever the output register is empty or being taken, so a
// steady stream runs at one item per cycle.
module vector3_normalize
    import vn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_vec_in  i_data,
    output logic     o_ready,
    output logic     o_valid,
    output t_vec_out o_data,
    input  logic     i_ready
);

    localparam int NST = 3 + ROOT_STAGES + DIV_STAGES;
    localparam logic [QUO_W-1:0] LIMIT = QUO_W'(1) << UNIT_FRAC_BITS;

    logic w_adv;
    logic [NST-1:0] r_vld;

    logic [MAG_W-1:0] r_mag0 [NUM_LANES];
    logic [NUM_LANES-1:0] r_neg0;
    logic [SQ_W-1:0]  r_sq [NUM_LANES];
    logic [MAG_W-1:0] r_mag1 [NUM_LANES];
    logic [NUM_LANES-1:0] r_neg1;
    logic [SUM_W-1:0] r_sum;
    logic [MAG_W-1:0] r_mag2 [NUM_LANES];
    logic [NUM_LANES-1:0] r_neg2;

    t_root_st         r_rt  [ROOT_STAGES];
    t_root_st         w_rt  [ROOT_STAGES];
    logic [MAG_W-1:0] r_rmag [ROOT_STAGES][NUM_LANES];
    logic [NUM_LANES-1:0] r_rneg [ROOT_STAGES];

    t_div_st          r_dv  [DIV_STAGES][NUM_LANES];
    t_div_st          w_dv  [DIV_STAGES][NUM_LANES];
    logic [LEN_W-1:0] r_den [DIV_STAGES];
    logic [NUM_LANES-1:0] r_dneg [DIV_STAGES];

    t_vec_out r_out;
    t_vec_out n_out;
    logic     r_out_vld;

    logic [COMP_WIDTH-1:0] w_raw [NUM_LANES];
    logic [QUO_W-1:0] w_q [NUM_LANES];
    logic [UNIT_OUT_WIDTH-1:0] w_u [NUM_LANES];

    assign w_adv   = !r_out_vld || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    assign w_raw[0] = i_data.comp_x;
    assign w_raw[1] = i_data.comp_y;
    assign w_raw[2] = i_data.comp_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[NST-2:0], i_valid};
            r_out_vld <= r_vld[NST-1];
        end
    end

    // Front: sign split, squares, sum
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                r_neg0[k] <= w_raw[k][COMP_WIDTH-1];
                r_mag0[k] <= w_raw[k][COMP_WIDTH-1] ? (MAG_W'(0) - w_raw[k]) : w_raw[k];
                r_sq[k]   <= SQ_W'(r_mag0[k]) * SQ_W'(r_mag0[k]);
            end
            r_mag1 <= r_mag0;
            r_neg1 <= r_neg0;
            r_sum  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_mag2 <= r_mag1;
            r_neg2 <= r_neg1;
        end
    end

    // Root pipeline
    genvar gs, gl;
    generate
        for (gs = 0; gs < ROOT_STAGES; gs++) begin : g_root
            t_root_st w_in;
            logic [MAG_W-1:0] w_mag [NUM_LANES];
            logic [NUM_LANES-1:0] w_neg;
            if (gs == 0) begin : g_first
                assign w_in  = '{s: r_sum, rem: '0, root: '0};
                assign w_mag = r_mag2;
                assign w_neg = r_neg2;
            end else begin : g_next
                assign w_in  = r_rt[gs-1];
                assign w_mag = r_rmag[gs-1];
                assign w_neg = r_rneg[gs-1];
            end
            vn_root_step u_step (.i_st(w_in), .o_st(w_rt[gs]));
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_rt[gs]   <= w_rt[gs];
                    r_rmag[gs] <= w_mag;
                    r_rneg[gs] <= w_neg;
                end
            end
        end

        // Divider lanes, one per component
        for (gs = 0; gs < DIV_STAGES; gs++) begin : g_div
            logic [LEN_W-1:0] w_den;
            logic [NUM_LANES-1:0] w_neg;
            if (gs == 0) begin : g_first
                assign w_den = r_rt[ROOT_STAGES-1].root;
                assign w_neg = r_rneg[ROOT_STAGES-1];
            end else begin : g_next
                assign w_den = r_den[gs-1];
                assign w_neg = r_dneg[gs-1];
            end
            for (gl = 0; gl < NUM_LANES; gl++) begin : g_lane
                t_div_st w_in;
                if (gs == 0) begin : g_first
                    assign w_in.rem = DREM_W'(r_rmag[ROOT_STAGES-1][gl]) << (LEN_FRAC_BITS - 1);
                    assign w_in.quo = '0;
                end else begin : g_next
                    assign w_in = r_dv[gs-1][gl];
                end
                vn_div_step u_step (.i_st(w_in), .i_den(w_den), .o_st(w_dv[gs][gl]));
            end
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_dv[gs]   <= w_dv[gs];
                    r_den[gs]  <= w_den;
                    r_dneg[gs] <= w_neg;
                end
            end
        end
    endgenerate

    // Merge: clamp, apply signs, handle the zero vector
    always_comb begin
        logic zero;
        zero = (r_den[DIV_STAGES-1] == '0);
        for (int k = 0; k < NUM_LANES; k++) begin
            w_q[k] = r_dv[DIV_STAGES-1][k].quo;
            if (w_q[k] > LIMIT) begin
                w_q[k] = LIMIT;
            end
            w_u[k] = r_dneg[DIV_STAGES-1][k] ? (UNIT_OUT_WIDTH'(0) - UNIT_OUT_WIDTH'(w_q[k]))
                                             : UNIT_OUT_WIDTH'(w_q[k]);
            if (zero) begin
                w_u[k] = '0;
            end
        end
        n_out.unit_x      = w_u[0];
        n_out.unit_y      = w_u[1];
        n_out.unit_z      = w_u[2];
        n_out.length_q8   = LEN_OUT_WIDTH'(r_den[DIV_STAGES-1]);
        n_out.zero_vector = zero;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

endmodule

### hdl/vn_root_step.sv
// One restoring square-root digit: brings in the next bit pair and settles one root bit.
module vn_root_step
    import vn_pkg::*;
(
    input  t_root_st i_st,
    output t_root_st o_st
);

    logic [REM_W-1:0] w_cat;
    logic [REM_W-1:0] w_trial;
    logic             w_take;

    always_comb begin
        w_cat   = {i_st.rem[REM_W-3:0], i_st.s[SUM_W-1:SUM_W-2]};
        w_trial = {i_st.root, 2'b01};
        w_take  = (w_cat >= w_trial);
        o_st.s    = {i_st.s[SUM_W-3:0], 2'b00};
        o_st.rem  = w_take ? (w_cat - w_trial) : w_cat;
        o_st.root = {i_st.root[LEN_W-2:0], w_take};
    end

endmodule

### hdl/vn_div_step.sv
// One restoring division step of a lane: shift the remainder and settle one quotient bit.
module vn_div_step
    import vn_pkg::*;
(
    input  t_div_st          i_st,
    input  logic [LEN_W-1:0] i_den,
    output t_div_st          o_st
);

    logic [DREM_W-1:0] w_sh;
    logic              w_take;

    always_comb begin
        w_sh   = {i_st.rem[DREM_W-2:0], 1'b0};
        w_take = (w_sh >= {1'b0, i_den});
        o_st.rem = w_take ? (w_sh - {1'b0, i_den}) : w_sh;
        o_st.quo = {i_st.quo[QUO_W-2:0], w_take};
    end

endmodule

### tb/vector3_normalize_tb.sv
// Testbench for the vector normaliser: random and corner vectors against a fixed-point predictor.
module vector3_normalize_tb;
    import vn_pkg::*;

    // Expected-result store and checker for normalised vectors.
    class norm_scoreboard;
        t_vec_out pending[$];
        int       errors;

        static function logic [63:0] root_q8(logic [63:0] s);
            logic [63:0] rem;
            logic [63:0] root;
            logic [63:0] trial;
            logic [63:0] pair;
            rem = 0;
            root = 0;
            for (int i = 31 + LEN_FRAC_BITS; i >= 0; i--) begin
                pair = 0;
                if (i >= LEN_FRAC_BITS) pair = (s >> (2 * (i - LEN_FRAC_BITS))) & 3;
                rem = (rem << 2) | pair;
                trial = (root << 2) | 1;
                if (rem >= trial) begin
                    rem = rem - trial;
                    root = (root << 1) | 1;
                end else begin
                    root = root << 1;
                end
            end
            return root;
        endfunction

        static function logic [63:0] unit_quot(logic [63:0] a, logic [63:0] d);
            logic [63:0] lim;
            logic [63:0] q;
            lim = 64'd1 << UNIT_FRAC_BITS;
            q = (a << (UNIT_FRAC_BITS + LEN_FRAC_BITS)) / d;
            return (q > lim) ? lim : q;
        endfunction

        function void note_vector(t_vec_in v);
            logic signed [COMP_WIDTH-1:0] c[3];
            logic [63:0] mag[3];
            logic [63:0] sum;
            logic [63:0] len;
            logic [63:0] q;
            logic [UNIT_OUT_WIDTH-1:0] u[3];
            t_vec_out r;
            c[0] = v.comp_x;
            c[1] = v.comp_y;
            c[2] = v.comp_z;
            sum = 0;
            for (int k = 0; k < 3; k++) begin
                mag[k] = c[k] < 0 ? 64'(-65'(c[k])) : 64'(c[k]);
                sum += mag[k] * mag[k];
            end
            r = '0;
            if (sum == 0) begin
                r.zero_vector = 1'b1;
            end else begin
                len = root_q8(sum);
                for (int k = 0; k < 3; k++) begin
                    q = unit_quot(mag[k], len);
                    u[k] = c[k] < 0 ? UNIT_OUT_WIDTH'(-q) : UNIT_OUT_WIDTH'(q);
                end
                r.unit_x = u[0];
                r.unit_y = u[1];
                r.unit_z = u[2];
                r.length_q8 = len[LEN_OUT_WIDTH-1:0];
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_vec_out got);
            t_vec_out want;
            if (pending.size() == 0) begin
                report("unexpected result", 0, got);
                return;
            end
            want = pending.pop_front();
            if (got.unit_x !== want.unit_x) report("unit_x", want.unit_x, got.unit_x);
            if (got.unit_y !== want.unit_y) report("unit_y", want.unit_y, got.unit_y);
            if (got.unit_z !== want.unit_z) report("unit_z", want.unit_z, got.unit_z);
            if (got.length_q8 !== want.length_q8)
                report("length_q8", want.length_q8, got.length_q8);
            if (got.zero_vector !== want.zero_vector)
                report("zero_vector", want.zero_vector, got.zero_vector);
        endfunction

        function void report(string what, logic [127:0] want, logic [127:0] got);
            errors++;
            $display("MISMATCH %s: expected %0h got %0h at %0t", what, want, got, $time);
        endfunction
    endclass

    localparam int LATENCY   = 43;
    localparam int WATCHDOG  = 4000;
    localparam int N_RANDOM  = 400;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    t_vec_in  i_data = '0;
    logic     o_ready;
    logic     o_valid;
    t_vec_out o_data;
    logic     i_ready = 1'b0;

    norm_scoreboard board = new();
    bit       sending_done = 1'b0;
    bit       calm = 1'b0;
    int       idle_cycles = 0;

    vector3_normalize dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_ready (i_ready)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [COMP_WIDTH-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return COMP_WIDTH'($urandom_range(0, 7)) - 16'sd3;
            1: return 16'h8000 + COMP_WIDTH'($urandom_range(0, 3));
            2: return 16'h7fff - COMP_WIDTH'($urandom_range(0, 3));
            3: return '0;
            default: return COMP_WIDTH'($urandom());
        endcase
    endfunction

    // Offer one item and hold it until taken; drop valid only while idling.
    task automatic send_vector(t_vec_in v);
        while (!calm && $urandom_range(0, 99) < 18) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_vector(v);
    endtask

    initial begin
        t_vec_in v;
        logic signed [COMP_WIDTH-1:0] corners[6];
        corners = '{16'sh7fff, -16'sh7fff, 16'sh8000, 16'sd1, -16'sd1, 16'sd0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_vector('{16'sd0, 16'sd0, 16'sd0});
        send_vector('{16'sh8000, 16'sh8000, 16'sh8000});
        send_vector('{16'sh7fff, 16'sh7fff, 16'sh7fff});
        send_vector('{16'sh8000, 16'sd0, 16'sd0});
        send_vector('{16'sd0, 16'sd1, 16'sd0});
        send_vector('{16'sd0, 16'sd0, -16'sd1});
        send_vector('{16'sd3, 16'sd4, 16'sd0});
        send_vector('{16'hffff, 16'haaaa, 16'h5555});
        for (int k = 0; k < 12; k++) begin
            v.comp_x = corners[k % 6];
            v.comp_y = corners[(k + 2) % 6];
            v.comp_z = corners[(k * 5 + 1) % 6];
            send_vector(v);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 150 && n < 230);
            v.comp_x = rand_comp();
            v.comp_y = rand_comp();
            v.comp_z = rand_comp();
            send_vector(v);
        end
        i_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: random stalls, one long hold-off to fill the pipeline.
    initial begin
        int hold;
        hold = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) board.check_result(o_data);
            if (board.pending.size() > 20 && hold == 0) hold = 1;
            if (hold > 0 && hold < 200) begin
                hold++;
                i_ready <= 1'b0;
            end else begin
                i_ready <= calm || ($urandom_range(0, 99) >= 18);
            end
        end
    end

    // Watchdog and end of run.
    initial begin
        int tail;
        tail = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("vector3_normalize test failed");
                $finish;
            end
            if (sending_done && board.pending.size() == 0) tail++;
            if (tail > LATENCY + 10) begin
                if (o_valid) board.report("extra result after end", '0, o_data);
                if (board.errors == 0) begin
                    $display("vector3_normalize test passed");
                end else begin
                    $display("vector3_normalize test failed");
                end
                $finish;
            end
        end
    end

endmodule

### sim.f
hdl/vn_pkg.sv
hdl/vn_root_step.sv
hdl/vn_div_step.sv
hdl/vector3_normalize.sv
tb/vector3_normalize_tb.sv
